[design/ahfb_pkg.sv]
// Shared types, constants and helpers for the ASCII hex frame builder.
package ahfb_pkg;

   localparam logic [7:0]  SOH_BYTE     = 8'h01;
   localparam logic [7:0]  LF_BYTE      = 8'h0A;
   localparam logic [15:0] LEN_OVERHEAD = 16'd6;
   localparam int unsigned HEX_BASE     = 16;

   localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_TEXT  = 1'b1;

   // at most one command per accepted transaction, handed from front to back
   typedef struct packed {
      logic        is_text;   // 0: header (SOH + length digits), 1: one text byte
      logic        trailer;   // checksum digits and LF follow
      logic [15:0] data;      // frame length for a header, text byte in [7:0]
      logic [7:0]  csum;      // checksum as it stands after this command
   } cmd_type;

   function automatic logic [7:0] hex_digit(input logic [3:0] nib);
      logic [7:0] res;
      if (nib < 4'(HEX_BASE - 6)) begin
         res = 8'h30 + {4'h0, nib};
      end else begin
         res = 8'h57 + {4'h0, nib};
      end
      return res;
   endfunction

endpackage

[design/ahfb_front.sv]
// Front end: accepts transactions, tracks frame state and issues commands.
module ahfb_front
   import ahfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  logic        func,
   input  logic [15:0] text_length,
   input  logic [7:0]  text_byte,
   input  logic        q_full,
   output logic        q_push,
   output cmd_type     q_cmd
);

   logic [7:0]  running_xor_ff, running_xor_in;
   logic [15:0] bytes_remaining_ff, bytes_remaining_in;
   logic        frame_open_ff, frame_open_in;

   logic        accept;
   logic [15:0] flen;
   logic [7:0]  head_xor;
   logic [7:0]  text_xor;
   logic [15:0] rem_dec;

   assign accept   = push && !q_full;
   assign flen     = text_length + LEN_OVERHEAD;
   assign head_xor = SOH_BYTE ^ hex_digit(flen[15:12]) ^ hex_digit(flen[11:8])
                   ^ hex_digit(flen[7:4]) ^ hex_digit(flen[3:0]);
   assign text_xor = running_xor_ff ^ text_byte;
   assign rem_dec  = bytes_remaining_ff - 16'd1;

   always_comb begin
      running_xor_in     = running_xor_ff;
      bytes_remaining_in = bytes_remaining_ff;
      frame_open_in      = frame_open_ff;
      q_push             = 1'b0;
      q_cmd              = '0;
      if (accept) begin
         if (func == FUNC_START) begin
            q_push         = 1'b1;
            q_cmd.is_text  = 1'b0;
            q_cmd.trailer  = (text_length == 16'd0);
            q_cmd.data     = flen;
            q_cmd.csum     = head_xor;
            running_xor_in = head_xor;
            bytes_remaining_in = text_length;
            frame_open_in  = (text_length != 16'd0);
         end else if (frame_open_ff) begin
            q_push         = 1'b1;
            q_cmd.is_text  = 1'b1;
            q_cmd.trailer  = (rem_dec == 16'd0);
            q_cmd.data     = {8'h00, text_byte};
            q_cmd.csum     = text_xor;
            running_xor_in = text_xor;
            bytes_remaining_in = rem_dec;
            frame_open_in  = (rem_dec != 16'd0);
         end
         // text byte with no frame open: dropped
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_xor_ff     <= '0;
         bytes_remaining_ff <= '0;
         frame_open_ff      <= 1'b0;
      end else begin
         running_xor_ff     <= running_xor_in;
         bytes_remaining_ff <= bytes_remaining_in;
         frame_open_ff      <= frame_open_in;
      end
   end

endmodule

[design/ahfb_cmd_queue.sv]
// Short command queue between the front end and the byte sequencer.
module ahfb_cmd_queue
   import ahfb_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type head_cmd
);

   localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

   cmd_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full     = (count_ff == FULL_COUNT);
   assign valid    = (count_ff != '0);
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[design/ahfb_back.sv]
// Back end: expands commands into frame bytes behind a one-entry output register.
module ahfb_back
   import ahfb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  cmd_type    q_cmd,
   output logic       q_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   // byte positions within a command; a text byte sits at the last digit slot
   localparam logic [2:0] POS_SOH     = 3'd0;
   localparam logic [2:0] POS_DIG3    = 3'd1;
   localparam logic [2:0] POS_DIG2    = 3'd2;
   localparam logic [2:0] POS_DIG1    = 3'd3;
   localparam logic [2:0] POS_DIG0    = 3'd4;
   localparam logic [2:0] POS_CSUM_HI = 3'd5;
   localparam logic [2:0] POS_CSUM_LO = 3'd6;
   localparam logic [2:0] POS_LF      = 3'd7;

   logic [2:0] step_ff, step_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;

   logic       load;
   logic [2:0] pos;
   logic [2:0] last_pos;
   logic       last;
   logic [7:0] cur_byte;

   assign load     = q_valid && (!out_valid_ff || rsp_pop);
   assign pos      = q_cmd.is_text ? step_ff + POS_DIG0 : step_ff;
   assign last_pos = q_cmd.trailer ? POS_LF : POS_DIG0;
   assign last     = (pos == last_pos);
   assign q_pop    = load && last;

   always_comb begin
      unique case (pos)
         POS_SOH:     cur_byte = SOH_BYTE;
         POS_DIG3:    cur_byte = hex_digit(q_cmd.data[15:12]);
         POS_DIG2:    cur_byte = hex_digit(q_cmd.data[11:8]);
         POS_DIG1:    cur_byte = hex_digit(q_cmd.data[7:4]);
         POS_DIG0:    cur_byte = q_cmd.is_text ? q_cmd.data[7:0]
                                               : hex_digit(q_cmd.data[3:0]);
         POS_CSUM_HI: cur_byte = hex_digit(q_cmd.csum[7:4]);
         POS_CSUM_LO: cur_byte = hex_digit(q_cmd.csum[3:0]);
         POS_LF:      cur_byte = LF_BYTE;
         default:     cur_byte = LF_BYTE;
      endcase
   end

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (load) begin
         out_valid_in = 1'b1;
         out_byte_in  = cur_byte;
         out_last_in  = last;
         step_in      = last ? 3'd0 : step_ff + 3'd1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_empty    = !out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = out_last_ff;

endmodule

[design/ascii_hex_frame_builder.sv]
// Top level of the ASCII hex frame builder.
//
// Input side is a queue: a transaction is taken when req_push is high and
// req_full is low. req_func 0 opens a frame of req_text_length text bytes,
// req_func 1 carries one text byte in req_text_byte (dropped if no frame).
// Result side is a queue: rsp_out_byte/rsp_run_last are valid while rsp_empty
// is low and are taken when rsp_pop is high.
// A start yields SOH and four hex length digits (plus checksum digits and LF
// when the text is empty); a text byte yields itself (plus the trailer when
// it closes the frame). rsp_run_last marks the final byte of each transaction.
// The first byte passes through the command queue and the output register.
// The front end takes one transaction a cycle while req_full is low; the back
// end emits one byte a cycle while rsp_pop is high, so text bytes stream at one
// per cycle and header/trailer bytes drain from the command queue (QUEUE_DEPTH
// entries) while req_full holds the sender off.
// Reset clears the frame state, the queue and the output register.
// If the receiver stalls, the output byte holds, the queue fills, then
// req_full rises; nothing is lost.
module ascii_hex_frame_builder
   import ahfb_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_func,
   input  logic [15:0] req_text_length,
   input  logic [7:0]  req_text_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last
);

   logic    q_push, q_full, q_pop, q_valid;
   cmd_type push_cmd, head_cmd;

   assign req_full = q_full;

   ahfb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (req_push),
      .func        (req_func),
      .text_length (req_text_length),
      .text_byte   (req_text_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (push_cmd)
   );

   ahfb_cmd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head_cmd (head_cmd)
   );

   ahfb_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_cmd        (head_cmd),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

`ifndef SYNTH
   a_pop_needs_cmd : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("command popped from empty queue");

   a_push_not_full : assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command pushed into full queue");

   a_reset_clears : assert property (@(posedge clock)
      reset |=> rsp_empty && !q_valid)
      else $error("output or queue not cleared by reset");
`endif

endmodule
